// ===== rtl/plw_pkg.sv =====
// ----------------------------------------------------------------------------
// plw_pkg
// Shared types and codes for the palette letterbox pixel writer.
// ----------------------------------------------------------------------------
package plw_pkg;

	// command codes on the input channel
	localparam logic [1:0] CMD_PIXEL  = 2'd0;
	localparam logic [1:0] CMD_PAL_WR = 2'd1;
	localparam logic [1:0] CMD_PAL_RD = 2'd2;

	// result kinds
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_PAL_RD = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_SCANLINE   = 2'd2;
	localparam logic [1:0] CFG_GREYSCALE  = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int COLOUR_W   = 24;
	localparam int ADDR_W     = 17;
	localparam int XY_W       = 11;	// framebuffer column/row incl. offsets
	localparam int PROD_W     = 2 * XY_W;

	// luma weights
	localparam logic [7:0] LUMA_R = 8'd77;
	localparam logic [7:0] LUMA_G = 8'd150;
	localparam logic [7:0] LUMA_B = 8'd29;

	// position of one pixel, decided when the beat is taken
	typedef struct packed {
		logic [XY_W-1:0] fb_x;
		logic [XY_W-1:0] fb_y;
		logic            last;
		logic            blank;
		logic            grey;
	} pix_pos_t;

endpackage

// ===== rtl/plw_palette.sv =====
// ----------------------------------------------------------------------------
// plw_palette
// Palette RAM, one write and one registered read per cycle. Per-entry valid
// bits make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
module plw_palette
	import plw_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [7:0]          wr_slot,
	input  logic [COLOUR_W-1:0] wr_data,
	input  logic                rd_en,
	input  logic [7:0]          rd_slot,
	output logic [COLOUR_W-1:0] rd_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [COLOUR_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0]  vld_q;
	logic [IDX_W-1:0]    wrap_tbl [256];
	logic [IDX_W-1:0]    wa, ra;
	logic [COLOUR_W-1:0] rd_q;
	logic                rd_vld_q;

	// slot modulo entry count, as a constant table
	for (genvar i = 0; i < 256; i++) begin : g_wrap
		assign wrap_tbl[i] = IDX_W'(i % ENTRIES);
	end

	assign wa = wrap_tbl[wr_slot];
	assign ra = wrap_tbl[rd_slot];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[ra];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/plw_raster.sv =====
// ----------------------------------------------------------------------------
// plw_raster
// Configuration registers and the source column/row counters. Gives the
// letterboxed framebuffer position of the pixel being taken.
// ----------------------------------------------------------------------------
module plw_raster
	import plw_pkg::*;
#(
	parameter int FRAME_WIDTH       = 320,
	parameter int FRAME_HEIGHT      = 240,
	parameter int MAX_SOURCE_WIDTH  = 256,
	parameter int MAX_SOURCE_HEIGHT = 228
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	output pix_pos_t              pos
);

	localparam int X_BASE = (FRAME_WIDTH - MAX_SOURCE_WIDTH) / 2;
	localparam int Y_BASE = (FRAME_HEIGHT - MAX_SOURCE_HEIGHT) / 2;
	localparam logic [8:0] MAX_W = 9'(MAX_SOURCE_WIDTH);
	localparam logic [7:0] MAX_H = 8'(MAX_SOURCE_HEIGHT);

	logic [8:0] src_w_q;
	logic [7:0] src_h_q;
	logic       scan_q, grey_q;
	logic [7:0] col_q, row_q;

	logic [8:0] w, c_nx, r_nx;
	logic [7:0] h, r_inc, r_a, c0, r0, col_d, row_d;
	logic [8:0] x_off;
	logic [7:0] y_off;
	logic       wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= MAX_W;
			src_h_q <= MAX_H;
			scan_q  <= 1'b0;
			grey_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_w_q <= cfg_data;
				CFG_SRC_HEIGHT: src_h_q <= cfg_data[7:0];
				CFG_SCANLINE:   scan_q  <= cfg_data[0];
				CFG_GREYSCALE:  grey_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w = (src_w_q == '0) ? 9'd1 : ((src_w_q > MAX_W) ? MAX_W : src_w_q);
		h = (src_h_q == '0) ? 8'd1 : ((src_h_q > MAX_H) ? MAX_H : src_h_q);
		x_off = (MAX_W - w) >> 1;
		y_off = (MAX_H - h) >> 1;

		// a shrunk frame may leave the counters out of range
		wrap  = {1'b0, col_q} >= w;
		r_inc = row_q + 8'd1;
		r_a   = wrap ? r_inc : row_q;
		c0    = wrap ? 8'd0 : col_q;
		r0    = (r_a >= h) ? 8'd0 : r_a;

		c_nx = {1'b0, c0} + 9'd1;
		r_nx = {1'b0, r0} + 9'd1;
		if (c_nx >= w) begin
			col_d = 8'd0;
			row_d = (r_nx >= {1'b0, h}) ? 8'd0 : r_nx[7:0];
		end else begin
			col_d = c_nx[7:0];
			row_d = r0;
		end

		pos.fb_x  = XY_W'(X_BASE) + XY_W'(x_off) + XY_W'(c0);
		pos.fb_y  = XY_W'(Y_BASE) + XY_W'(y_off) + XY_W'(r0);
		pos.last  = ({1'b0, c0} == w - 9'd1) && (r0 == h - 8'd1);
		pos.blank = scan_q & r0[0];
		pos.grey  = grey_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

// ===== rtl/palette_letterbox_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// palette_letterbox_pixel_writer
// Indexed-colour pixel writer: palette RAM lookup, letterbox placement in the
// framebuffer and RGB332 packing, with optional luma grey and scanlines.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | cmd, pixel_index, palette_slot,
//          |           |                       | write_colour
//  out     | output    | out_valid / out_ready | result_kind, fb_address,
//          |           |                       | fb_pixel, read_colour, frame_last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One beat per clock unless an output stall holds a full s1. A result
//  passes the palette RAM read (s1), then conversion and address multiply
//  into the output register. Palette writes and command 3 produce no result.
//  Reset clears the palette valid bits and counters and sets the config
//  defaults at once; no clearing pass. An output stall holds s1 and the RAM
//  read register; input is still taken while s1 is empty.
// ----------------------------------------------------------------------------
module palette_letterbox_pixel_writer
	import plw_pkg::*;
#(
	parameter int FRAME_WIDTH       = 320,
	parameter int FRAME_HEIGHT      = 240,
	parameter int MAX_SOURCE_WIDTH  = 256,
	parameter int MAX_SOURCE_HEIGHT = 228,
	parameter int PALETTE_ENTRIES   = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic [7:0]            pixel_index,
	input  logic [7:0]            palette_slot,
	input  logic [COLOUR_W-1:0]   write_colour,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic [ADDR_W-1:0]     fb_address,
	output logic [7:0]            fb_pixel,
	output logic [COLOUR_W-1:0]   read_colour,
	output logic                  frame_last
);

	logic                accept, adv, is_pix, is_rd;
	logic [COLOUR_W-1:0] rd_data;
	pix_pos_t            pos, pos_s1;
	logic                vld_s1, kind_s1;

	logic [7:0]          r8, g8, b8, luma, px;
	logic [15:0]         luma_sum;
	logic [PROD_W-1:0]   addr_full;

	logic                out_vld_q, kind_q, last_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [7:0]          pix_q;
	logic [COLOUR_W-1:0] col_q;

	assign cfg_ready = 1'b1;
	assign adv       = !out_vld_q || out_ready;
	assign in_ready  = !vld_s1 || adv;
	assign accept    = in_valid && in_ready;
	assign is_pix    = (cmd == CMD_PIXEL);
	assign is_rd     = (cmd == CMD_PAL_RD);

	plw_palette #(
		.ENTRIES (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (cmd == CMD_PAL_WR)),
		.wr_slot (palette_slot),
		.wr_data (write_colour),
		.rd_en   (accept && (is_pix || is_rd)),
		.rd_slot (is_pix ? pixel_index : palette_slot),
		.rd_data (rd_data)
	);

	plw_raster #(
		.FRAME_WIDTH       (FRAME_WIDTH),
		.FRAME_HEIGHT      (FRAME_HEIGHT),
		.MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
		.MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept && is_pix),
		.pos       (pos)
	);

	// s1: RAM read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= accept && (is_pix || is_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= is_pix ? KIND_PIXEL : KIND_PAL_RD;
			pos_s1  <= pos;
		end
	end

	// colour conversion and framebuffer address
	always_comb begin
		r8 = rd_data[23:16];
		g8 = rd_data[15:8];
		b8 = rd_data[7:0];
		luma_sum = 16'(r8) * 16'(LUMA_R) + 16'(g8) * 16'(LUMA_G)
			+ 16'(b8) * 16'(LUMA_B);
		luma = luma_sum[15:8];
		if (pos_s1.blank) begin
			px = 8'd0;
		end else if (pos_s1.grey) begin
			px = {luma[7:5], luma[7:5], luma[7:6]};
		end else begin
			px = {r8[7:5], g8[7:5], b8[7:6]};
		end
		addr_full = pos_s1.fb_y * PROD_W'(FRAME_WIDTH) + PROD_W'(pos_s1.fb_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			kind_q <= kind_s1;
			if (kind_s1 == KIND_PIXEL) begin
				addr_q <= addr_full[ADDR_W-1:0];
				pix_q  <= px;
				col_q  <= '0;
				last_q <= pos_s1.last;
			end else begin
				addr_q <= '0;
				pix_q  <= '0;
				col_q  <= rd_data;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_vld_q;
	assign result_kind = kind_q;
	assign fb_address  = addr_q;
	assign fb_pixel    = pix_q;
	assign read_colour = col_q;
	assign frame_last  = last_q;

endmodule
